// ----- hdl/dmss_pkg.sv -----
// Shared types, constants and glyph ROMs for the dot-matrix status scroller.
// No dependencies; every other file refers to this package by scoped names.
package dmss_pkg;

   // Panel geometry and field widths
   localparam int PANEL_COLUMNS = 16;
   localparam int FLOOR_COLUMNS = 11;
   localparam int COL_W         = 4;
   localparam int DOT_W         = 8;
   localparam int STEP_W        = 6;
   localparam int ARROW_STEP_W  = 4;
   localparam int FLAG_W        = 10;
   localparam int ALARM_W       = 7;

   // Marquee, slide and arrow cycles
   localparam int MSG_SHORT   = 28;
   localparam int MSG_LONG    = 52;
   localparam int CYC_SHORT   = MSG_SHORT + FLOOR_COLUMNS;
   localparam int CYC_LONG    = MSG_LONG + FLOOR_COLUMNS;
   localparam int SLIDE_CYCLE = 9;
   localparam int SLIDE_END   = 8;
   localparam int ARROW_CYCLE = 11;
   localparam int ARROW_SHOWN = 8;

   // Status flag bit positions
   localparam int FLAG_FIRE      = 0;
   localparam int FLAG_STOP      = 1;
   localparam int FLAG_FULL      = 2;
   localparam int FLAG_EMERGENCY = 3;
   localparam int FLAG_AUTO      = 4;
   localparam int FLAG_OVERLOAD  = 5;
   localparam int FLAG_PARKING   = 6;
   localparam int FLAG_SCROLL_EN = 7;
   localparam int FLAG_UP        = 8;
   localparam int FLAG_DOWN      = 9;

   // Request codes
   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_TICK  = 1'b1;

   typedef enum logic {
      ST_IDLE,
      ST_TICK
   } seq_state_type;

   typedef enum logic [1:0] {
      FM_HOLD,
      FM_COPY,
      FM_SLIDE,
      FM_MSG
   } floor_mode_type;

   typedef enum logic [1:0] {
      AM_HOLD,
      AM_COPY,
      AM_SHIFT
   } arrow_mode_type;

   // Per-tick decisions handed from the tick state to the column datapath
   typedef struct packed {
      floor_mode_type          floor_mode;
      arrow_mode_type          arrow_mode;
      logic                    up;
      logic                    long_cyc;
      logic [STEP_W-1:0]       step;
      logic [3:0]              slide_sh;
      logic [2:0]              arrow_sh;
      logic [ALARM_W-1:0]      alarm_flags;
   } tick_ctrl_type;

   localparam logic [7:0] ROM_EMG [MSG_SHORT] = '{
      8'h00, 8'h00, 8'h7F, 8'h49, 8'h49, 8'h49, 8'h41, 8'h00,
      8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F, 8'h00, 8'h3E, 8'h41,
      8'h49, 8'h49, 8'h7A, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00};

   localparam logic [7:0] ROM_INS [MSG_SHORT] = '{
      8'h00, 8'h00, 8'h00, 8'h41, 8'h7F, 8'h41, 8'h00, 8'h00,
      8'h7F, 8'h04, 8'h08, 8'h10, 8'h7F, 8'h00, 8'h46, 8'h49,
      8'h49, 8'h49, 8'h31, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00};

   localparam logic [7:0] ROM_FIRE [MSG_SHORT] = '{
      8'h00, 8'h00, 8'h7F, 8'h09, 8'h09, 8'h09, 8'h01, 8'h00,
      8'h00, 8'h41, 8'h7F, 8'h41, 8'h00, 8'h00, 8'h7F, 8'h09,
      8'h19, 8'h29, 8'h46, 8'h00, 8'h7F, 8'h49, 8'h49, 8'h49,
      8'h41, 8'h00, 8'h00, 8'h00};

   localparam logic [7:0] ROM_STOP [MSG_SHORT] = '{
      8'h00, 8'h00, 8'h46, 8'h49, 8'h49, 8'h49, 8'h31, 8'h00,
      8'h01, 8'h01, 8'h7F, 8'h01, 8'h01, 8'h00, 8'h3E, 8'h41,
      8'h41, 8'h41, 8'h3E, 8'h00, 8'h7F, 8'h09, 8'h09, 8'h09,
      8'h06, 8'h00, 8'h00, 8'h00};

   localparam logic [7:0] ROM_FULL [MSG_SHORT] = '{
      8'h00, 8'h00, 8'h7F, 8'h09, 8'h09, 8'h09, 8'h01, 8'h00,
      8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F, 8'h00, 8'h7F, 8'h40,
      8'h40, 8'h40, 8'h40, 8'h00, 8'h7F, 8'h40, 8'h40, 8'h40,
      8'h40, 8'h00, 8'h00, 8'h00};

   localparam logic [7:0] ROM_OVL [MSG_LONG] = '{
      8'h00, 8'h00, 8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E, 8'h00,
      8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F, 8'h00, 8'h7F, 8'h49,
      8'h49, 8'h49, 8'h41, 8'h00, 8'h7F, 8'h09, 8'h19, 8'h29,
      8'h46, 8'h00, 8'h7F, 8'h40, 8'h40, 8'h40, 8'h40, 8'h00,
      8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E, 8'h00, 8'h7E, 8'h11,
      8'h11, 8'h11, 8'h7E, 8'h00, 8'h7F, 8'h41, 8'h41, 8'h22,
      8'h1C, 8'h00, 8'h00, 8'h00};

   localparam logic [7:0] ROM_PARK [MSG_LONG] = '{
      8'h00, 8'h00, 8'h7F, 8'h09, 8'h09, 8'h09, 8'h06, 8'h00,
      8'h7E, 8'h11, 8'h11, 8'h11, 8'h7E, 8'h00, 8'h7F, 8'h09,
      8'h19, 8'h29, 8'h46, 8'h00, 8'h7F, 8'h08, 8'h14, 8'h22,
      8'h41, 8'h00, 8'h00, 8'h41, 8'h7F, 8'h41, 8'h00, 8'h00,
      8'h7F, 8'h04, 8'h08, 8'h10, 8'h7F, 8'h00, 8'h3E, 8'h41,
      8'h49, 8'h49, 8'h7A, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00};

   // Message column at marquee position pos, picked by alarm priority
   function automatic logic [DOT_W-1:0] message_byte(input logic [STEP_W-1:0]  pos,
                                                     input logic [ALARM_W-1:0] f);
      logic [DOT_W-1:0] b;
      b = '0;
      if (pos < STEP_W'(MSG_SHORT)) begin
         priority if (f[FLAG_EMERGENCY]) b = ROM_EMG[pos[4:0]];
         else if (f[FLAG_PARKING])        b = ROM_PARK[pos];
         else if (!f[FLAG_AUTO])          b = ROM_INS[pos[4:0]];
         else if (f[FLAG_FIRE])           b = ROM_FIRE[pos[4:0]];
         else if (f[FLAG_STOP])           b = ROM_STOP[pos[4:0]];
         else if (f[FLAG_FULL])           b = ROM_FULL[pos[4:0]];
         else if (f[FLAG_OVERLOAD])       b = ROM_OVL[pos];
         else                             b = '0;
      end else if (pos < STEP_W'(MSG_LONG)) begin
         priority if (f[FLAG_PARKING])    b = ROM_PARK[pos];
         else if (f[FLAG_OVERLOAD])       b = ROM_OVL[pos];
         else                             b = '0;
      end
      return b;
   endfunction

endpackage

// ----- hdl/dmss_if.sv -----
// Valid/ready channel interfaces for request and response beats.
// Depends on dmss_pkg for field widths.
interface dmss_req_if;
   logic                         valid;
   logic                         ready;
   logic                         req_type;
   logic [dmss_pkg::COL_W-1:0]   column_index;
   logic [dmss_pkg::DOT_W-1:0]   column_value;
   logic [dmss_pkg::FLAG_W-1:0]  status_flags;
   logic                         floor_changed;

   modport source (output valid, req_type, column_index, column_value, status_flags,
                   floor_changed, input ready);
   modport sink   (input valid, req_type, column_index, column_value, status_flags,
                   floor_changed, output ready);
endinterface

interface dmss_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [dmss_pkg::COL_W-1:0]   frame_column;
   logic [dmss_pkg::DOT_W-1:0]   frame_bits;
   logic                         last;

   modport source (output valid, frame_column, frame_bits, last, input ready);
   modport sink   (input valid, frame_column, frame_bits, last, output ready);
endinterface

// ----- hdl/dot_matrix_status_scroller_top.sv -----
// Dot-matrix status scroller. A write beat stores a glyph column.
// A tick beat emits 16 frame columns through the read stage and the output register,
// one per cycle while the sink does not stall; the next beat is taken once the sweep has drained.
// The column sweep reads the glyph and frame memories and writes each new column back to the frame memory.
// Synchronous active-high reset clears the control state and valid bits; memories read as zero until written.
module dot_matrix_status_scroller_top #(
   parameter int ARROW_COLUMNS = 5
) (
   input  logic        clock,
   input  logic        reset,
   dmss_req_if.sink    req_if,
   dmss_rsp_if.source  rsp_if
);

   dmss_pkg::seq_state_type     state_ff, state_in;
   logic [dmss_pkg::COL_W:0]    issue_col_ff, issue_col_in;
   logic                        p1_vld_ff, p1_vld_in;
   logic [dmss_pkg::COL_W-1:0]  p1_col_ff;
   logic [dmss_pkg::STEP_W-1:0] p1_pos_ff;
   logic                        rsp_vld_ff, rsp_vld_in;
   logic [dmss_pkg::COL_W-1:0]  rsp_col_ff;
   logic [dmss_pkg::DOT_W-1:0]  rsp_bits_ff;
   logic                        rsp_last_ff;

   logic                        req_ready, issue, out_free, consume;
   logic                        req_acc, tick_go, glyph_we;
   logic [dmss_pkg::COL_W-1:0]  issue_addr, glyph_raddr;
   logic [dmss_pkg::STEP_W:0]   pos_sum, pos_cyc;
   logic [dmss_pkg::STEP_W-1:0] issue_pos, msg_len;
   logic [dmss_pkg::DOT_W-1:0]  glyph_rd, frame_rd, col_bits;
   dmss_pkg::tick_ctrl_type     tick_ctrl;

   // handshake decode
   assign req_acc  = req_if.valid && req_ready;
   assign tick_go  = req_acc && (req_if.req_type == dmss_pkg::REQ_TICK);
   assign glyph_we = req_acc && (req_if.req_type == dmss_pkg::REQ_WRITE);
   assign out_free = !rsp_vld_ff || rsp_if.ready;
   assign consume  = p1_vld_ff && out_free;

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dmss_pkg::ST_IDLE: if (tick_go) state_in = dmss_pkg::ST_TICK;
         dmss_pkg::ST_TICK: begin
            if (issue_col_ff == 5'(dmss_pkg::PANEL_COLUMNS) && !p1_vld_ff) begin
               state_in = dmss_pkg::ST_IDLE;
            end
         end
         default:           state_in = dmss_pkg::ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_ready = 1'b0;
      issue     = 1'b0;
      unique case (state_ff)
         dmss_pkg::ST_IDLE: req_ready = 1'b1;
         dmss_pkg::ST_TICK: issue = (issue_col_ff != 5'(dmss_pkg::PANEL_COLUMNS))
                                    && (!p1_vld_ff || out_free);
         default:           req_ready = 1'b0;
      endcase
   end

   assign req_if.ready = req_ready;

   // marquee position and glyph address of the column being issued
   assign issue_addr = issue_col_ff[dmss_pkg::COL_W-1:0];
   assign pos_sum    = {1'b0, tick_ctrl.step} + 7'(issue_addr);
   assign pos_cyc    = tick_ctrl.long_cyc ? 7'(dmss_pkg::CYC_LONG) : 7'(dmss_pkg::CYC_SHORT);
   assign issue_pos  = (pos_sum >= pos_cyc) ? 6'(pos_sum - pos_cyc)
                                            : pos_sum[dmss_pkg::STEP_W-1:0];
   assign msg_len    = tick_ctrl.long_cyc ? 6'(dmss_pkg::MSG_LONG) : 6'(dmss_pkg::MSG_SHORT);

   always_comb begin
      glyph_raddr = issue_addr;
      if (tick_ctrl.floor_mode == dmss_pkg::FM_MSG
          && issue_addr < 4'(dmss_pkg::FLOOR_COLUMNS) && issue_pos >= msg_len) begin
         glyph_raddr = 4'(issue_pos - msg_len);
      end
   end

   // pipeline control
   always_comb begin
      issue_col_in = issue_col_ff;
      if (tick_go) begin
         issue_col_in = '0;
      end else if (issue) begin
         issue_col_in = issue_col_ff + 5'd1;
      end
      p1_vld_in = p1_vld_ff;
      if (issue) begin
         p1_vld_in = 1'b1;
      end else if (consume) begin
         p1_vld_in = 1'b0;
      end
      rsp_vld_in = rsp_vld_ff;
      if (consume) begin
         rsp_vld_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dmss_pkg::ST_IDLE;
         issue_col_ff <= '0;
         p1_vld_ff    <= 1'b0;
         rsp_vld_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         issue_col_ff <= issue_col_in;
         p1_vld_ff    <= p1_vld_in;
         rsp_vld_ff   <= rsp_vld_in;
      end
   end

   // read stage tags and output register
   always_ff @(posedge clock) begin
      if (issue) begin
         p1_col_ff <= issue_addr;
         p1_pos_ff <= issue_pos;
      end
      if (consume) begin
         rsp_col_ff  <= p1_col_ff;
         rsp_bits_ff <= col_bits;
         rsp_last_ff <= (p1_col_ff == 4'(dmss_pkg::PANEL_COLUMNS - 1));
      end
   end

   assign rsp_if.valid        = rsp_vld_ff;
   assign rsp_if.frame_column = rsp_col_ff;
   assign rsp_if.frame_bits   = rsp_bits_ff;
   assign rsp_if.last         = rsp_last_ff;

   dmss_tick u_tick (
      .clock         (clock),
      .reset         (reset),
      .tick_go       (tick_go),
      .status_flags  (req_if.status_flags),
      .floor_changed (req_if.floor_changed),
      .ctrl          (tick_ctrl)
   );

   dmss_mem u_glyph_mem (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (glyph_we),
      .wr_addr (req_if.column_index),
      .wr_data (req_if.column_value),
      .rd_en   (issue),
      .rd_addr (glyph_raddr),
      .rd_data (glyph_rd)
   );

   dmss_mem u_frame_mem (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (consume),
      .wr_addr (p1_col_ff),
      .wr_data (col_bits),
      .rd_en   (issue),
      .rd_addr (issue_addr),
      .rd_data (frame_rd)
   );

   dmss_col #(
      .ARROW_COLUMNS (ARROW_COLUMNS)
   ) u_col (
      .col   (p1_col_ff),
      .pos   (p1_pos_ff),
      .ctrl  (tick_ctrl),
      .glyph (glyph_rd),
      .frame (frame_rd),
      .bits  (col_bits)
   );

   // read stage is empty whenever the sequencer is idle
   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      state_ff == dmss_pkg::ST_IDLE |-> !p1_vld_ff)
      else $error("read stage busy while idle");

   // column in the read stage is the one just before the issue pointer
   a_col_order: assert property (@(posedge clock) disable iff (reset)
      p1_vld_ff |-> issue_col_ff == {1'b0, p1_col_ff} + 5'd1)
      else $error("read stage column out of order");

   // glyph memory is never written during a column sweep
   a_no_write_in_tick: assert property (@(posedge clock) disable iff (reset)
      state_ff == dmss_pkg::ST_TICK |-> !glyph_we)
      else $error("glyph write during tick");

   // an accepted tick starts a sweep from column zero
   a_tick_start: assert property (@(posedge clock) disable iff (reset)
      tick_go |=> state_ff == dmss_pkg::ST_TICK && issue_col_ff == '0)
      else $error("tick did not start sweep");

   // last flag marks exactly the final panel column
   a_last_col: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff |-> rsp_last_ff == (rsp_col_ff == 4'(dmss_pkg::PANEL_COLUMNS - 1)))
      else $error("last flag mismatch");

endmodule

// ----- hdl/dmss_mem.sv -----
// 16 x 8 column memory, one write and one registered read port.
// Per-entry valid bits make unwritten entries read as zero. Depends on dmss_pkg.
module dmss_mem (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          wr_en,
   input  logic [dmss_pkg::COL_W-1:0]    wr_addr,
   input  logic [dmss_pkg::DOT_W-1:0]    wr_data,
   input  logic                          rd_en,
   input  logic [dmss_pkg::COL_W-1:0]    rd_addr,
   output logic [dmss_pkg::DOT_W-1:0]    rd_data
);

   logic [dmss_pkg::DOT_W-1:0]         mem_ff [dmss_pkg::PANEL_COLUMNS];
   logic [dmss_pkg::PANEL_COLUMNS-1:0] vld_ff;
   logic [dmss_pkg::DOT_W-1:0]         rd_data_ff;
   logic                               rd_ok_ff;

   // storage array, no reset
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // valid bits, cleared by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (wr_en) begin
         vld_ff[wr_addr] <= 1'b1;
      end
   end

   // registered read, holds while rd_en is low
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
         rd_ok_ff   <= vld_ff[rd_addr];
      end
   end

   assign rd_data = rd_ok_ff ? rd_data_ff : '0;

endmodule

// ----- hdl/dmss_tick.sv -----
// Per-tick state: scroll step, slide and marquee flags, arrow step.
// Decides the floor and arrow modes for one tick. Depends on dmss_pkg.
module dmss_tick (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          tick_go,
   input  logic [dmss_pkg::FLAG_W-1:0]   status_flags,
   input  logic                          floor_changed,
   output dmss_pkg::tick_ctrl_type       ctrl
);

   logic [dmss_pkg::STEP_W-1:0]       scroll_step_ff, scroll_step_in;
   logic                              slide_pend_ff, slide_pend_in;
   logic                              msg_act_ff, msg_act_in;
   logic [dmss_pkg::ARROW_STEP_W-1:0] arrow_step_ff, arrow_step_in;
   dmss_pkg::tick_ctrl_type           ctrl_ff, ctrl_in;

   logic                              short_cyc, alarm, dir_en;
   logic [dmss_pkg::STEP_W-1:0]       s0;
   logic                              sp0;
   logic [dmss_pkg::STEP_W:0]         inc, cyc;
   logic [dmss_pkg::STEP_W:0]         slide_inc;
   logic [dmss_pkg::STEP_W-1:0]       slide_step;
   logic [dmss_pkg::ARROW_STEP_W:0]   arrow_inc;
   logic [dmss_pkg::ARROW_STEP_W-1:0] arrow_nxt;
   dmss_pkg::arrow_mode_type          arrow_mode;
   logic [2:0]                        arrow_sh;

   assign short_cyc = status_flags[dmss_pkg::FLAG_AUTO:dmss_pkg::FLAG_FIRE] != 5'b10000;
   assign alarm     = short_cyc || status_flags[dmss_pkg::FLAG_OVERLOAD]
                      || status_flags[dmss_pkg::FLAG_PARKING];
   assign dir_en    = status_flags[dmss_pkg::FLAG_SCROLL_EN]
                      && (status_flags[dmss_pkg::FLAG_UP] || status_flags[dmss_pkg::FLAG_DOWN]);

   // floor change restarts the slide before anything else
   assign s0  = floor_changed ? '0 : scroll_step_ff;
   assign sp0 = floor_changed || slide_pend_ff;

   // floor area decision
   always_comb begin
      scroll_step_in = s0;
      slide_pend_in  = sp0;
      msg_act_in     = msg_act_ff;
      ctrl_in        = '0;
      inc            = '0;
      cyc            = '0;
      slide_inc      = '0;
      slide_step     = '0;
      ctrl_in.up          = status_flags[dmss_pkg::FLAG_UP];
      ctrl_in.long_cyc    = !short_cyc;
      ctrl_in.alarm_flags = status_flags[dmss_pkg::ALARM_W-1:0];
      ctrl_in.floor_mode  = dmss_pkg::FM_HOLD;
      ctrl_in.arrow_mode  = arrow_mode;
      ctrl_in.arrow_sh    = arrow_sh;

      if (alarm) begin
         cyc = short_cyc ? 7'(dmss_pkg::CYC_SHORT) : 7'(dmss_pkg::CYC_LONG);
         inc = {1'b0, s0} + 7'd1;
         scroll_step_in     = (inc >= cyc) ? 6'(inc - cyc) : inc[dmss_pkg::STEP_W-1:0];
         msg_act_in         = 1'b1;
         ctrl_in.floor_mode = dmss_pkg::FM_MSG;
      end else begin
         // marquee just ended: show the plain glyph
         if (msg_act_ff) begin
            slide_pend_in      = 1'b0;
            scroll_step_in     = '0;
            msg_act_in         = 1'b0;
            ctrl_in.floor_mode = dmss_pkg::FM_COPY;
         end
         if (slide_pend_in) begin
            if (dir_en) begin
               slide_inc  = {1'b0, scroll_step_in} + 7'd1;
               slide_step = (slide_inc >= 7'(dmss_pkg::SLIDE_CYCLE))
                            ? 6'(slide_inc - 7'(dmss_pkg::SLIDE_CYCLE))
                            : slide_inc[dmss_pkg::STEP_W-1:0];
               scroll_step_in     = slide_step;
               ctrl_in.floor_mode = dmss_pkg::FM_SLIDE;
               ctrl_in.slide_sh   = 4'(dmss_pkg::SLIDE_END) - slide_step[3:0];
               if (slide_step == 6'(dmss_pkg::SLIDE_END)) begin
                  slide_pend_in = 1'b0;
               end
            end else begin
               slide_pend_in      = 1'b0;
               scroll_step_in     = '0;
               ctrl_in.floor_mode = dmss_pkg::FM_COPY;
            end
         end
      end
      ctrl_in.step = scroll_step_in;
   end

   // arrow decision
   always_comb begin
      arrow_inc     = {1'b0, arrow_step_ff} + 5'd1;
      arrow_nxt     = (arrow_inc >= 5'(dmss_pkg::ARROW_CYCLE))
                      ? 4'(arrow_inc - 5'(dmss_pkg::ARROW_CYCLE))
                      : arrow_inc[dmss_pkg::ARROW_STEP_W-1:0];
      arrow_step_in = '0;
      arrow_mode    = dmss_pkg::AM_COPY;
      arrow_sh      = '0;
      if (dir_en) begin
         arrow_step_in = arrow_nxt;
         if (arrow_nxt < 4'(dmss_pkg::ARROW_SHOWN)) begin
            arrow_mode = dmss_pkg::AM_SHIFT;
            arrow_sh   = 3'(dmss_pkg::ARROW_SHOWN - 1) - arrow_nxt[2:0];
         end else begin
            arrow_mode = dmss_pkg::AM_HOLD;
         end
      end
   end

   // tick state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         scroll_step_ff <= '0;
         slide_pend_ff  <= 1'b0;
         msg_act_ff     <= 1'b0;
         arrow_step_ff  <= '0;
      end else if (tick_go) begin
         scroll_step_ff <= scroll_step_in;
         slide_pend_ff  <= slide_pend_in;
         msg_act_ff     <= msg_act_in;
         arrow_step_ff  <= arrow_step_in;
      end
   end

   // decisions held for the column sweep
   always_ff @(posedge clock) begin
      if (tick_go) begin
         ctrl_ff <= ctrl_in;
      end
   end

   assign ctrl = ctrl_ff;

endmodule

// ----- hdl/dmss_col.sv -----
// Column datapath: new frame column from glyph, old frame and tick decisions.
// Depends on dmss_pkg for modes, widths and the message ROMs.
module dmss_col #(
   parameter int ARROW_COLUMNS = 5
) (
   input  logic [dmss_pkg::COL_W-1:0]    col,
   input  logic [dmss_pkg::STEP_W-1:0]   pos,
   input  dmss_pkg::tick_ctrl_type       ctrl,
   input  logic [dmss_pkg::DOT_W-1:0]    glyph,
   input  logic [dmss_pkg::DOT_W-1:0]    frame,
   output logic [dmss_pkg::DOT_W-1:0]    bits
);

   localparam int ARROW_END = dmss_pkg::FLOOR_COLUMNS + ARROW_COLUMNS;

   logic [dmss_pkg::STEP_W-1:0] msg_len;
   logic                        is_floor, is_arrow;

   assign msg_len  = ctrl.long_cyc ? 6'(dmss_pkg::MSG_LONG) : 6'(dmss_pkg::MSG_SHORT);
   assign is_floor = col < 4'(dmss_pkg::FLOOR_COLUMNS);
   assign is_arrow = {1'b0, col} < 5'(ARROW_END);

   always_comb begin
      bits = frame;
      if (is_floor) begin
         unique case (ctrl.floor_mode)
            dmss_pkg::FM_HOLD:  bits = frame;
            dmss_pkg::FM_COPY:  bits = glyph;
            // one new dot row per tick slides in from the top or bottom
            dmss_pkg::FM_SLIDE: bits = ctrl.up ? ((frame >> 1) | (glyph << ctrl.slide_sh))
                                               : ((frame << 1) | (glyph >> ctrl.slide_sh));
            dmss_pkg::FM_MSG:   bits = (pos < msg_len)
                                       ? dmss_pkg::message_byte(pos, ctrl.alarm_flags)
                                       : glyph;
            default:            bits = frame;
         endcase
      end else if (is_arrow) begin
         unique case (ctrl.arrow_mode)
            dmss_pkg::AM_HOLD:  bits = frame;
            dmss_pkg::AM_COPY:  bits = glyph;
            dmss_pkg::AM_SHIFT: bits = ctrl.up ? (glyph << ctrl.arrow_sh)
                                               : (glyph >> ctrl.arrow_sh);
            default:            bits = frame;
         endcase
      end
   end

endmodule
